// ----- src/tgad_pkg.sv -----
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types, constants and helpers of the Targa pixel payload decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int DIM_W       = 13;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
   localparam int         RUN_FLAG_BIT = 7;
   localparam int         RUN_LEN_W    = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_ALPHA_PRESENT = 3'd2,
      REG_RLE_MODE      = 3'd3,
      REG_TOP_DOWN      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic alpha_present;
      logic rle_mode;
      logic top_down;
   } cfg_flags_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > maxv) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

endpackage

// ----- src/tgad_req_if.sv -----
// ----------------------------------------------------------------------------
// tgad_req_if
// Request channel: one payload byte per request.
// ----------------------------------------------------------------------------
interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- src/tgad_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tgad_rsp_if
// Response channel: one pixel or run per response.
// ----------------------------------------------------------------------------
interface tgad_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_address;
   logic [31:0] argb_value;
   logic [7:0]  run_length;
   logic        run_clipped;
   logic        image_done;

   modport source (output valid, output pixel_address, output argb_value,
                   output run_length, output run_clipped, output image_done,
                   input ready);
   modport sink   (input valid, input pixel_address, input argb_value,
                   input run_length, input run_clipped, input image_done,
                   output ready);
endinterface

// ----- src/tgad_csr_if.sv -----
// ----------------------------------------------------------------------------
// tgad_csr_if
// Register write channel: index and data per write.
// ----------------------------------------------------------------------------
interface tgad_csr_if import tgad_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/tgad_csr_regs.sv -----
// ----------------------------------------------------------------------------
// tgad_csr_regs
// Configuration registers; dimensions are stored already clamped.
// ----------------------------------------------------------------------------
module tgad_csr_regs import tgad_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic          clock,
   input  logic          reset,
   tgad_csr_if.sink      csr_bus,
   output logic [WW-1:0] img_width,
   output logic [HW-1:0] img_height,
   output cfg_flags_type flags,
   output logic          restart
);

   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   cfg_flags_type flags_ff,  flags_in;
   logic          write;

   assign csr_bus.ready = 1'b1;
   assign write         = csr_bus.valid;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      flags_in  = flags_ff;
      restart   = 1'b0;
      if (write) begin
         restart = 1'b1;
         case (csr_bus.index)
            REG_IMAGE_WIDTH:   width_in  = WW'(clamp_dim(csr_bus.data, MAX_WIDTH));
            REG_IMAGE_HEIGHT:  height_in = HW'(clamp_dim(csr_bus.data, MAX_HEIGHT));
            REG_ALPHA_PRESENT: flags_in.alpha_present = csr_bus.data[0];
            REG_RLE_MODE:      flags_in.rle_mode      = csr_bus.data[0];
            REG_TOP_DOWN:      flags_in.top_down      = csr_bus.data[0];
            default:           restart = 1'b0;   // unknown index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(1);
         height_ff <= HW'(1);
         flags_ff  <= '{alpha_present: 1'b0, rle_mode: 1'b1, top_down: 1'b0};
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         flags_ff  <= flags_in;
      end
   end

   assign img_width  = width_ff;
   assign img_height = height_ff;
   assign flags      = flags_ff;

endmodule

// ----- src/tgad_decode.sv -----
// ----------------------------------------------------------------------------
// tgad_decode
// Packet and pixel state; registers one pixel or run with its position.
// ----------------------------------------------------------------------------
module tgad_decode import tgad_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int HW  = $clog2(MAX_HEIGHT + 1),
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int RLW = $clog2(MAX_HEIGHT)
) (
   input  logic                 clock,
   input  logic                 reset,
   tgad_req_if.sink             req_bus,
   input  logic [WW-1:0]        img_width,
   input  logic [HW-1:0]        img_height,
   input  cfg_flags_type        flags,
   input  logic                 restart,
   output logic                 mid_valid,
   input  logic                 mid_ready,
   output logic [RLW-1:0]       mid_drow,
   output logic [CLW-1:0]       mid_column,
   output logic [31:0]          mid_argb,
   output logic [RUN_LEN_W-1:0] mid_len,
   output logic                 mid_clipped,
   output logic                 mid_done
);

   localparam int CMPW = (WW > RUN_LEN_W) ? WW : RUN_LEN_W;

   logic                 expect_ff,  expect_in;
   logic                 is_run_ff,  is_run_in;
   logic                 discard_ff, discard_in;
   logic [7:0]           left_ff,    left_in;
   logic [1:0]           bip_ff,     bip_in;
   logic [23:0]          color_ff,   color_in;
   logic [CLW-1:0]       col_ff,     col_in;
   logic [RLW-1:0]       row_ff,     row_in;

   logic                 mv_ff,      mv_in;
   logic [RLW-1:0]       drow_ff,    drow_in;
   logic [CLW-1:0]       mcol_ff;
   logic [31:0]          argb_ff,    argb_in;
   logic [RUN_LEN_W-1:0] len_ff,     len_in;
   logic                 clip_ff,    clip_in;
   logic                 done_ff,    done_in;

   logic                 accept;
   logic                 emit;
   logic [7:0]           b;
   logic [1:0]           last;
   logic [7:0]           left_dec;
   logic [WW-1:0]        room;
   logic [CMPW:0]        col_sum;

   assign req_bus.ready = !mv_ff || mid_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.stream_byte;
   assign last          = flags.alpha_present ? 2'd3 : 2'd2;
   assign room          = img_width - WW'(col_ff);
   assign left_dec      = (left_ff == 8'd0) ? 8'd0 : left_ff - 8'd1;

   always_comb begin
      expect_in  = expect_ff;
      is_run_in  = is_run_ff;
      discard_in = discard_ff;
      left_in    = left_ff;
      bip_in     = bip_ff;
      color_in   = color_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      emit       = 1'b0;
      len_in     = RUN_LEN_W'(1);
      clip_in    = 1'b0;
      done_in    = 1'b0;
      argb_in    = '0;
      drow_in    = flags.top_down ? row_ff
                                  : RLW'(img_height - HW'(1) - HW'(row_ff));
      col_sum    = '0;

      if (accept) begin
         if (flags.rle_mode && expect_ff) begin
            is_run_in  = b[RUN_FLAG_BIT];
            left_in    = {1'b0, b[RUN_FLAG_BIT-1:0]} + 8'd1;
            expect_in  = 1'b0;
            discard_in = 1'b0;
            bip_in     = 2'd0;
         end else begin
            case (bip_ff)
               2'd0:    color_in[7:0]   = b;
               2'd1:    color_in[15:8]  = b;
               2'd2:    color_in[23:16] = b;
               default: ;               // alpha byte: keep color
            endcase
            if (bip_ff != last) begin
               bip_in = bip_ff + 2'd1;
            end else begin
               bip_in  = 2'd0;
               argb_in = {flags.alpha_present ? b : ALPHA_OPAQUE, color_in};
               if (!flags.rle_mode) begin
                  emit = 1'b1;
               end else if (is_run_ff) begin
                  // cut the run at the row end
                  if (CMPW'(left_ff) < CMPW'(room)) begin
                     len_in = left_ff;
                  end else begin
                     len_in = RUN_LEN_W'(room);
                  end
                  clip_in   = CMPW'(left_ff) > CMPW'(room);
                  left_in   = 8'd0;
                  expect_in = 1'b1;
                  emit      = 1'b1;
               end else begin
                  left_in = left_dec;
                  if (discard_ff) begin
                     if (left_dec == 8'd0) begin
                        expect_in  = 1'b1;
                        discard_in = 1'b0;
                     end
                  end else begin
                     clip_in    = (room == WW'(1)) && (left_dec != 8'd0);
                     discard_in = clip_in;
                     if (left_dec == 8'd0) begin
                        expect_in = 1'b1;
                     end
                     emit = 1'b1;
                  end
               end
            end
         end
      end

      if (emit) begin
         col_sum = (CMPW+1)'(col_ff) + (CMPW+1)'(len_in);
         if (col_sum >= (CMPW+1)'(img_width)) begin
            col_in = '0;
            if ((HW'(row_ff) + HW'(1)) >= img_height) begin
               row_in  = '0;
               done_in = 1'b1;
            end else begin
               row_in = row_ff + RLW'(1);
            end
         end else begin
            col_in = col_sum[CLW-1:0];
         end
      end

      if (restart) begin
         expect_in  = 1'b1;
         is_run_in  = 1'b0;
         discard_in = 1'b0;
         left_in    = 8'd0;
         bip_in     = 2'd0;
         color_in   = '0;
         col_in     = '0;
         row_in     = '0;
      end
   end

   // hold the pixel register while the address stage is stalled
   always_comb begin
      mv_in = mv_ff;
      if (!mv_ff || mid_ready) begin
         mv_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff  <= 1'b1;
         is_run_ff  <= 1'b0;
         discard_ff <= 1'b0;
         left_ff    <= 8'd0;
         bip_ff     <= 2'd0;
         color_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         mv_ff      <= 1'b0;
      end else begin
         expect_ff  <= expect_in;
         is_run_ff  <= is_run_in;
         discard_ff <= discard_in;
         left_ff    <= left_in;
         bip_ff     <= bip_in;
         color_ff   <= color_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         mv_ff      <= mv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         drow_ff <= drow_in;
         mcol_ff <= col_ff;
         argb_ff <= argb_in;
         len_ff  <= len_in;
         clip_ff <= clip_in;
         done_ff <= done_in;
      end
   end

   assign mid_valid   = mv_ff;
   assign mid_drow    = drow_ff;
   assign mid_column  = mcol_ff;
   assign mid_argb    = argb_ff;
   assign mid_len     = len_ff;
   assign mid_clipped = clip_ff;
   assign mid_done    = done_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      mv_ff |-> (len_ff != '0) && (len_ff <= RUN_LEN_W'(128)))
      else $error("run length out of range");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < img_width)
      else $error("column past row end");

   a_discard_state: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> !expect_ff && (left_ff != 8'd0))
      else $error("dropping pixels with no packet left");

   a_alpha_byte: assert property (@(posedge clock) disable iff (reset)
      (bip_ff == 2'd3) |-> flags.alpha_present)
      else $error("alpha byte index without alpha");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mv_ff && !mid_ready |=> mv_ff && $stable(argb_ff) && $stable(len_ff))
      else $error("pixel register changed while stalled");

endmodule

// ----- src/tgad_addr.sv -----
// ----------------------------------------------------------------------------
// tgad_addr
// Buffer address (row times width plus column) and response register.
// ----------------------------------------------------------------------------
module tgad_addr import tgad_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int RLW = $clog2(MAX_HEIGHT)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WW-1:0]        img_width,
   input  logic                 mid_valid,
   output logic                 mid_ready,
   input  logic [RLW-1:0]       mid_drow,
   input  logic [CLW-1:0]       mid_column,
   input  logic [31:0]          mid_argb,
   input  logic [RUN_LEN_W-1:0] mid_len,
   input  logic                 mid_clipped,
   input  logic                 mid_done,
   tgad_rsp_if.source           rsp_bus
);

   logic        ov_ff, ov_in;
   logic [23:0] addr_ff, addr_in;
   logic [31:0] argb_ff;
   logic [7:0]  len_ff;
   logic        clip_ff;
   logic        done_ff;
   logic        load;

   assign mid_ready = !ov_ff || rsp_bus.ready;
   assign load      = mid_valid && mid_ready;
   // only the low 24 address bits are kept
   assign addr_in   = 24'(mid_drow) * 24'(img_width) + 24'(mid_column);

   always_comb begin
      ov_in = ov_ff;
      if (mid_ready) begin
         ov_in = mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= addr_in;
         argb_ff <= mid_argb;
         len_ff  <= 8'(mid_len);
         clip_ff <= mid_clipped;
         done_ff <= mid_done;
      end
   end

   assign rsp_bus.valid         = ov_ff;
   assign rsp_bus.pixel_address = addr_ff;
   assign rsp_bus.argb_value    = argb_ff;
   assign rsp_bus.run_length    = len_ff;
   assign rsp_bus.run_clipped   = clip_ff;
   assign rsp_bus.image_done    = done_ff;

endmodule

// ----- src/tga_rle_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Targa pixel payload decoder, run-length or plain, one byte per request.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle with no gaps of its own while responses are
// taken: each request only updates the packet and pixel counters and captures
// a color byte. A pixel or run that completes on a request is registered in
// the pixel stage, its buffer address is formed by one 24-bit multiply in the
// address stage, and the response is registered there with that address.
// Every register write (known index) restarts the stream at the first pixel
// and needs no clearing time. Widths and heights of zero act as one, larger
// than MAX_WIDTH / MAX_HEIGHT act as the maximum. Run packets that pass the
// row end are cut there with run_clipped set; raw packets that pass it flag
// the pixel that fills the row and drop the rest of their pixels.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top import tgad_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   tgad_req_if.sink    req_bus,
   tgad_rsp_if.source  rsp_bus,
   tgad_csr_if.sink    csr_bus
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int RLW = $clog2(MAX_HEIGHT);

   logic [WW-1:0]        img_width;
   logic [HW-1:0]        img_height;
   cfg_flags_type        flags;
   logic                 restart;

   logic                 mid_valid;
   logic                 mid_ready;
   logic [RLW-1:0]       mid_drow;
   logic [CLW-1:0]       mid_column;
   logic [31:0]          mid_argb;
   logic [RUN_LEN_W-1:0] mid_len;
   logic                 mid_clipped;
   logic                 mid_done;

   tgad_csr_regs #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .img_width  (img_width),
      .img_height (img_height),
      .flags      (flags),
      .restart    (restart)
   );

   tgad_decode #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .img_width   (img_width),
      .img_height  (img_height),
      .flags       (flags),
      .restart     (restart),
      .mid_valid   (mid_valid),
      .mid_ready   (mid_ready),
      .mid_drow    (mid_drow),
      .mid_column  (mid_column),
      .mid_argb    (mid_argb),
      .mid_len     (mid_len),
      .mid_clipped (mid_clipped),
      .mid_done    (mid_done)
   );

   tgad_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr (
      .clock       (clock),
      .reset       (reset),
      .img_width   (img_width),
      .mid_valid   (mid_valid),
      .mid_ready   (mid_ready),
      .mid_drow    (mid_drow),
      .mid_column  (mid_column),
      .mid_argb    (mid_argb),
      .mid_len     (mid_len),
      .mid_clipped (mid_clipped),
      .mid_done    (mid_done),
      .rsp_bus     (rsp_bus)
   );

endmodule

// ----- tb/tb_tga_rle_pixel_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_top
// Self-checking bench for the Targa pixel payload decoder.
// ----------------------------------------------------------------------------
// Feeds payload bytes through the request channel and writes image settings
// through the register channel while the decoder is idle. A behavioral
// decoder inside the bench follows every accepted request and queues the
// pixel or run it should produce; each response is checked field by field
// against the oldest queued result. A short directed part covers the default
// 1x1 image, clipped runs, clipped raw packets with dropped pixels, plain
// pixels with alpha, out-of-range sizes, unmapped register writes and a
// restart in the middle of a pixel. Random settings and packet streams
// follow, with random stalls on both channels except near the end.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_top import tgad_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_W = DEF_MAX_WIDTH;
   localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
   localparam int unsigned DIM_TOP = (1 << DIM_W) - 1;
   localparam int unsigned RANDOM_BYTES = 800;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct {
      logic [23:0] address;
      logic [31:0] argb;
      logic [7:0]  length;
      logic        clipped;
      logic        done;
   } pixel_result_type;

   logic clock;
   logic reset;

   tgad_req_if req_bus ();
   tgad_rsp_if rsp_bus ();
   tgad_csr_if csr_bus ();

   tga_rle_pixel_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [7:0]       payload_q[$];
   pixel_result_type expected_pixels[$];

   // settings and decode state as the decoder should hold them
   logic [DIM_W-1:0] cfg_width = 1;
   logic [DIM_W-1:0] cfg_height = 1;
   logic             cfg_alpha = 1'b0;
   logic             cfg_rle = 1'b1;
   logic             cfg_top_down = 1'b0;
   logic             want_header = 1'b1;
   logic             run_packet = 1'b0;
   logic             dropping = 1'b0;
   int unsigned      packet_left = 0;
   int unsigned      byte_idx = 0;
   int unsigned      column = 0;
   int unsigned      row = 0;
   logic [23:0]      color = '0;

   bit          quiet_tail = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int unsigned mismatches = 0;
   int unsigned bytes_taken = 0;
   int unsigned results_checked = 0;
   int unsigned images_done = 0;
   int unsigned settings_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned pixel_limit(logic [DIM_W-1:0] v, int unsigned ceiling);
      if (v == '0) return 1;
      return (v > ceiling) ? ceiling : int'(v);
   endfunction

   // queue one result and advance the write position
   function automatic void record_pixel(logic [31:0] argb, int unsigned len, logic clipped);
      int unsigned      w;
      int unsigned      h;
      int unsigned      disp_row;
      pixel_result_type res;
      w = pixel_limit(cfg_width, MAX_W);
      h = pixel_limit(cfg_height, MAX_H);
      disp_row = cfg_top_down ? row : h - 1 - row;
      res.address = 24'(disp_row * w + column);
      res.argb = argb;
      res.length = 8'(len);
      res.clipped = clipped;
      res.done = 1'b0;
      column += len;
      if (column >= w) begin
         column = 0;
         row++;
         if (row >= h) begin
            row = 0;
            res.done = 1'b1;
         end
      end
      expected_pixels.push_back(res);
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int unsigned room;
      int unsigned len;
      logic [7:0]  alpha;
      logic        clip;
      if (cfg_rle && want_header) begin
         run_packet = b[RUN_FLAG_BIT];
         packet_left = b[6:0] + 1;
         want_header = 1'b0;
         dropping = 1'b0;
         byte_idx = 0;
         return;
      end
      if (byte_idx < 3) color[8*byte_idx +: 8] = b;
      if (byte_idx < (cfg_alpha ? 3 : 2)) begin
         byte_idx++;
         return;
      end
      byte_idx = 0;
      alpha = cfg_alpha ? b : ALPHA_OPAQUE;
      if (!cfg_rle) begin
         record_pixel({alpha, color}, 1, 1'b0);
         return;
      end
      room = pixel_limit(cfg_width, MAX_W) - column;
      if (run_packet) begin
         len = (packet_left < room) ? packet_left : room;
         clip = packet_left > room;
         packet_left = 0;
         want_header = 1'b1;
         record_pixel({alpha, color}, len, clip);
         return;
      end
      if (packet_left > 0) packet_left--;
      if (dropping) begin
         if (packet_left == 0) begin
            want_header = 1'b1;
            dropping = 1'b0;
         end
         return;
      end
      clip = (room == 1) && (packet_left > 0);
      if (clip) dropping = 1'b1;
      if (packet_left == 0) want_header = 1'b1;
      record_pixel({alpha, color}, 1, clip);
   endfunction

   function automatic logic [7:0] header_byte(bit is_run, int unsigned count);
      return {is_run, 7'(count - 1)};
   endfunction

   // blue, green, red, then alpha when the image carries it
   function automatic void push_pixel(logic [31:0] argb);
      payload_q.push_back(argb[7:0]);
      payload_q.push_back(argb[15:8]);
      payload_q.push_back(argb[23:16]);
      if (cfg_alpha) payload_q.push_back(argb[31:24]);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   // leaves valid high; the caller drops it after the last write
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx <= REG_TOP_DOWN) begin
         case (idx)
            REG_IMAGE_WIDTH:   cfg_width = val;
            REG_IMAGE_HEIGHT:  cfg_height = val;
            REG_ALPHA_PRESENT: cfg_alpha = val[0];
            REG_RLE_MODE:      cfg_rle = val[0];
            REG_TOP_DOWN:      cfg_top_down = val[0];
            default: ;
         endcase
         // any mapped write restarts the stream
         want_header = 1'b1;
         run_packet = 1'b0;
         dropping = 1'b0;
         packet_left = 0;
         byte_idx = 0;
         color = '0;
         column = 0;
         row = 0;
      end
   endtask

   task automatic configure(int unsigned w, int unsigned h, bit a, bit r, bit t);
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_ALPHA_PRESENT, CSR_DATA_W'(a));
      write_reg(REG_RLE_MODE, CSR_DATA_W'(r));
      write_reg(REG_TOP_DOWN, CSR_DATA_W'(t));
      if ($urandom_range(0, 7) == 0)
         write_reg(CSR_INDEX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                   CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      settings_count++;
   endtask

   task automatic drain();
      while (payload_q.size() > 0 || req_bus.valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.stream_byte);
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (payload_q.size() > 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_bus.valid <= 1'b0;
            end else if (payload_q.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.stream_byte <= payload_q.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response expected none got addr %h argb %h len %0d",
                        $time, rsp_bus.pixel_address, rsp_bus.argb_value, rsp_bus.run_length);
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_address", want.address, rsp_bus.pixel_address);
               check_field("argb_value", want.argb, rsp_bus.argb_value);
               check_field("run_length", want.length, rsp_bus.run_length);
               check_field("run_clipped", want.clipped, rsp_bus.run_clipped);
               check_field("image_done", want.done, rsp_bus.image_done);
               results_checked++;
               if (want.done) images_done++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned count;
      int unsigned random_bytes;
      bit          is_run;

      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      random_bytes = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // defaults: 1x1 bottom-up run-length image without alpha
      @(negedge clock);
      payload_q.push_back(header_byte(1'b1, 128));
      push_pixel(32'h0000_0000);
      payload_q.push_back(header_byte(1'b0, 2));
      push_pixel(32'h00ff_ffff);
      push_pixel(32'h0055_aa33);
      drain();

      // width above the maximum, height zero, plain pixels with alpha
      configure(DIM_TOP, 0, 1'b1, 1'b0, 1'b1);
      @(negedge clock);
      push_pixel(32'h0000_0000);
      push_pixel(32'hffff_ffff);
      payload_q.push_back(8'h12);
      payload_q.push_back(8'h34);
      drain();

      // an unmapped write must leave the half-built pixel alone
      write_reg(REG_UNMAPPED_HI, '1);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
      payload_q.push_back(8'h56);
      payload_q.push_back(8'h78);
      payload_q.push_back(8'h9a);
      drain();

      // restart mid-pixel; largest image, bottom row first
      configure(MAX_W, MAX_H, 1'b0, 1'b1, 1'b0);
      @(negedge clock);
      payload_q.push_back(header_byte(1'b1, 1));
      push_pixel(32'h00c0_ffee);
      drain();

      while (random_bytes < RANDOM_BYTES) begin
         if (random_bytes > RANDOM_BYTES * 7 / 8) quiet_tail = 1'b1;
         case ($urandom_range(0, 19))
            0:       w = 0;
            1:       w = MAX_W;
            2:       w = $urandom_range(MAX_W + 1, DIM_TOP);
            3, 4, 5: w = $urandom_range(9, 40);
            default: w = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 15))
            0:       h = 0;
            1:       h = MAX_H;
            2:       h = $urandom_range(MAX_H + 1, DIM_TOP);
            default: h = $urandom_range(1, 4);
         endcase
         configure(w, h, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                   1'($urandom_range(0, 1)));
         @(negedge clock);
         repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 11) == 0) begin
               // stray bytes that break packet alignment
               repeat ($urandom_range(1, 5)) payload_q.push_back(8'($urandom));
            end else if (!cfg_rle) begin
               push_pixel($urandom);
            end else begin
               is_run = 1'($urandom_range(0, 1));
               count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
                                                   : $urandom_range(1, 6);
               payload_q.push_back(header_byte(is_run, count));
               repeat (is_run ? 1 : count) push_pixel($urandom);
            end
         end
         random_bytes += payload_q.size();
         drain();
      end

      $display("Sent %0d payload bytes under %0d image settings.", bytes_taken, settings_count);
      $display("Checked %0d pixel and run results, %0d of them closing an image.",
               results_checked, images_done);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
